### hdl/sha256_pkg.sv
`timescale 1ns / 1ps
package sha256_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } sha_item_t;

    typedef logic [31:0] word_t;

    localparam word_t H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic word_t round_k(input logic [5:0] r);
        word_t k;
        case (r)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

endpackage

### hdl/sha256_front.sv
`timescale 1ns / 1ps
module sha256_front
    import sha256_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_valid,
    output logic      s_ready,
    input  sha_item_t s_item,
    output logic      q_valid,
    input  logic      q_ready,
    output sha_item_t q_item
);

    localparam int DEPTH = 4;

    sha_item_t   mem_reg [DEPTH];
    logic [1:0]  wr_reg;
    logic [1:0]  rd_reg;
    logic [2:0]  cnt_reg;
    logic        push;
    logic        pop;
    logic        useful;

    // empty non-final requests are dropped here
    assign useful  = s_item.byte_present | s_item.end_of_message;
    assign s_ready = (cnt_reg != 3'(DEPTH));
    assign push    = s_valid & s_ready & useful;
    assign q_valid = (cnt_reg != 3'd0);
    assign pop     = q_valid & q_ready;
    assign q_item  = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= s_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 2'd1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + 3'(push) - 3'(pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'(DEPTH)) else $error("queue overflow");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 3'd1)
        else $error("count step");
    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (s_valid && s_ready && !useful && !pop) |=> $stable(cnt_reg))
        else $error("empty request queued");
`endif

endmodule

### hdl/sha256_back.sv
`timescale 1ns / 1ps
module sha256_back
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_ready,
    input  sha_item_t   q_item,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_word,
    output logic [2:0]  m_index,
    output logic        m_last
);

    typedef enum logic [2:0] {
        S_TAKE, S_LOAD, S_ROUND, S_ADD, S_PAD, S_OUT
    } state_t;

    state_t       state_reg;
    word_t        buf_reg [16];
    word_t        w_reg [16];
    word_t        h_reg [8];
    word_t        v_reg [8];
    logic [5:0]   fill_reg;
    logic [60:0]  total_reg;
    logic [5:0]   round_reg;
    logic [5:0]   pidx_reg;
    logic         final_reg;
    logic         second_reg;
    logic [63:0]  bits_reg;
    logic [2:0]   oidx_reg;
    logic         mv_reg;

    word_t w_cur, s0, s1, t1, t2, w_new;
    word_t w2, w7, w15, w16;

    assign q_ready = (state_reg == S_TAKE);
    assign m_valid = mv_reg;
    assign m_word  = h_reg[oidx_reg];
    assign m_index = oidx_reg;
    assign m_last  = (oidx_reg == 3'd7);

    always_comb
    begin
        w2    = w_reg[4'(round_reg - 6'd2)];
        w7    = w_reg[4'(round_reg - 6'd7)];
        w15   = w_reg[4'(round_reg - 6'd15)];
        w16   = w_reg[round_reg[3:0]];
        s1    = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
        s0    = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
        w_new = s1 + w7 + s0 + w16;
        w_cur = (round_reg < 6'd16) ? w16 : w_new;
        t1 = v_reg[7]
           + ({v_reg[4][5:0], v_reg[4][31:6]} ^ {v_reg[4][10:0], v_reg[4][31:11]}
              ^ {v_reg[4][24:0], v_reg[4][31:25]})
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + round_k(round_reg) + w_cur;
        t2 = ({v_reg[0][1:0], v_reg[0][31:2]} ^ {v_reg[0][12:0], v_reg[0][31:13]}
              ^ {v_reg[0][21:0], v_reg[0][31:22]})
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_TAKE:
            begin
                if (q_valid && q_item.byte_present)
                begin
                    buf_reg[fill_reg[5:2]][{~fill_reg[1:0], 3'd0} +: 8] <= q_item.data_byte;
                end
            end
            S_LOAD:
            begin
                w_reg[round_reg[3:0]] <= buf_reg[round_reg[3:0]];
                if (round_reg == 6'd15)
                begin
                    v_reg <= h_reg;
                end
            end
            S_ROUND:
            begin
                if (round_reg >= 6'd16)
                begin
                    w_reg[round_reg[3:0]] <= w_new;
                end
                v_reg <= '{t1 + t2, v_reg[0], v_reg[1], v_reg[2],
                           v_reg[3] + t1, v_reg[4], v_reg[5], v_reg[6]};
            end
            S_PAD:
            begin
                // pad byte, zero fill, then big-endian bit length in the last closing block
                if (pidx_reg == fill_reg && !second_reg)
                begin
                    buf_reg[pidx_reg[5:2]][{~pidx_reg[1:0], 3'd0} +: 8] <= PAD_BYTE;
                end
                else if (pidx_reg >= 6'd56 && !(fill_reg > 6'd55 && !second_reg))
                begin
                    buf_reg[pidx_reg[5:2]][{~pidx_reg[1:0], 3'd0} +: 8] <=
                        bits_reg[8'(6'd63 - pidx_reg) * 8 +: 8];
                end
                else if (pidx_reg > fill_reg || second_reg)
                begin
                    buf_reg[pidx_reg[5:2]][{~pidx_reg[1:0], 3'd0} +: 8] <= 8'h00;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_TAKE;
            h_reg      <= H_INIT;
            fill_reg   <= '0;
            total_reg  <= '0;
            round_reg  <= '0;
            pidx_reg   <= '0;
            final_reg  <= 1'b0;
            second_reg <= 1'b0;
            bits_reg   <= '0;
            oidx_reg   <= '0;
            mv_reg     <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_TAKE:
                begin
                    if (q_valid)
                    begin
                        final_reg  <= q_item.end_of_message;
                        second_reg <= 1'b0;
                        round_reg  <= '0;
                        pidx_reg   <= '0;
                        if (q_item.byte_present)
                        begin
                            fill_reg <= fill_reg + 6'd1;
                            bits_reg <= {total_reg + 61'(fill_reg) + 61'd1, 3'd0};
                            if (fill_reg == 6'd63)
                            begin
                                state_reg <= S_LOAD;
                            end
                            else if (q_item.end_of_message)
                            begin
                                state_reg <= S_PAD;
                            end
                        end
                        else
                        begin
                            bits_reg  <= {total_reg + 61'(fill_reg), 3'd0};
                            state_reg <= S_PAD;
                        end
                    end
                end
                S_LOAD:
                begin
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == 6'd15)
                    begin
                        round_reg <= '0;
                        state_reg <= S_ROUND;
                    end
                end
                S_ROUND:
                begin
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == 6'd63)
                    begin
                        state_reg <= S_ADD;
                    end
                end
                S_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    round_reg <= '0;
                    pidx_reg  <= '0;
                    if (!final_reg)
                    begin
                        total_reg <= total_reg + 61'd64;
                        fill_reg  <= '0;
                        state_reg <= S_TAKE;
                    end
                    else if (bits_reg[8:3] == 6'd0 && fill_reg == 6'd0 && !second_reg
                             && bits_reg[63:9] != total_reg[60:6])
                    begin
                        // full block closed on the final byte, padding follows
                        total_reg <= total_reg + 61'd64;
                        state_reg <= S_PAD;
                    end
                    else if (fill_reg > 6'd55 && !second_reg)
                    begin
                        second_reg <= 1'b1;
                        state_reg  <= S_PAD;
                    end
                    else
                    begin
                        oidx_reg  <= '0;
                        mv_reg    <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_PAD:
                begin
                    pidx_reg <= pidx_reg + 6'd1;
                    if (pidx_reg == 6'd63)
                    begin
                        state_reg <= S_LOAD;
                    end
                end
                S_OUT:
                begin
                    if (m_ready)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7)
                        begin
                            mv_reg    <= 1'b0;
                            h_reg     <= H_INIT;
                            fill_reg  <= '0;
                            total_reg <= '0;
                            state_reg <= S_TAKE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_TAKE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_valid_out: assert property (@(posedge clk) disable iff (!rst_n)
        mv_reg == (state_reg == S_OUT)) else $error("valid outside output");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid && !m_ready) |=> $stable(oidx_reg)) else $error("index moved");
    a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) |-> !q_ready) else $error("take during rounds");
`endif

endmodule

### hdl/sha256_stream_hasher_unit.sv
`timescale 1ns / 1ps
// byte requests pass a four-entry queue; one byte enters the buffer per cycle
// while bytes are taken, none while a block is loaded, hashed, padded or output
// a full block is loaded into the schedule, run through 64 rounds and added in
// the final request pads one or two closing blocks, then eight digest words follow
// later bytes wait in the queue while the single round unit hashes a block
// asynchronous active-low reset restores the initial hash values and empties the queue
module sha256_stream_hasher_unit
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic [1:0]  s_tuser,   // byte_present, end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // digest_word, word_index, zero fill
    output logic        m_tlast    // last_word
);

    sha_item_t   s_item, q_item;
    logic        q_valid, q_ready;
    logic [31:0] word;
    logic [2:0]  idx;

    assign s_item = '{data_byte: s_tdata, byte_present: s_tuser[0],
                      end_of_message: s_tuser[1]};

    sha256_front u_front (
        .clk(clk), .rst_n(rst_n),
        .s_valid(s_tvalid), .s_ready(s_tready), .s_item(s_item),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    sha256_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .m_valid(m_tvalid), .m_ready(m_tready),
        .m_word(word), .m_index(idx), .m_last(m_tlast)
    );

    assign m_tdata = {5'd0, idx, word};

endmodule
